FILE: src/csd_pkg.sv
package csd_pkg;

  // LCG recurrence: seed = seed * LCG_MUL + LCG_ADD
  localparam logic [31:0] LCG_MUL  = 32'h0003_43FD;
  localparam logic [31:0] LCG_ADD  = 32'h0026_9EC3;
  localparam logic [31:0] LCG_SEED = 32'h0000_0001;

  localparam logic [9:0] CIPHER_RESET = 10'd640;

  // archive layout
  localparam int unsigned FIRST_CIPHER_POS = 10;
  localparam int unsigned FLAG_POS         = 16;
  localparam int unsigned SUM_POS          = 18;
  localparam int unsigned HELD_DEPTH       = 6;

  // control of the shared LCG unit
  typedef struct packed {
    logic restart;
    logic step;
  } lcg_ctrl_t;

endpackage

FILE: src/codeplug_stream_decrypt.sv
// Stream decryptor for a configuration archive, one byte per transaction.
// Input channel: in_valid_i / in_stall_o carry data_byte_i and last_byte_i.
// Output channel: out_valid_o / out_stall_i carry out_byte_o, run_end_o,
// file_end_o and header_bad_o. A transaction moves when valid is high and
// stall is low. Config: cfg_valid_i / cfg_ready_o write cipher_length;
// write it only while the block is idle.
// Bytes 0..9 go straight to the emit step. Bytes 10..15 are held and
// leave with byte 16 as a burst of seven results; each result goes
// through the decode step, the key step when covered by the cipher, and
// the emit step. Bytes from 17 on take the same path, one result each.
// An archive ending at bytes 10..15 flushes its held bytes through the
// flush and emit steps. The shared LCG multiplier steps once per covered
// byte and the key update follows it in the next cycle.
// The block stalls its input while an item is being worked on. A stalled
// result holds in the output register; the sequencer waits in the emit
// step until it is taken.
// Reset (rst_ni, async, active low) restores cipher_length to 640 and the
// archive state; a transaction with last_byte_i set does the same for the
// archive state after its results are sent.
module codeplug_stream_decrypt #(
  parameter int unsigned FILE_MAX_BYTES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       file_end_o,
  output logic       header_bad_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i
);

  localparam int unsigned PW = $clog2(FILE_MAX_BYTES);
  localparam int unsigned CW = (PW > 10) ? PW : 10;
  localparam logic [PW-1:0] POS_MAX = PW'(FILE_MAX_BYTES - 1);
  localparam logic [PW-1:0] POS_FIRST = PW'(csd_pkg::FIRST_CIPHER_POS);
  localparam logic [PW-1:0] POS_FLAG = PW'(csd_pkg::FLAG_POS);
  localparam logic [PW-1:0] POS_SUM = PW'(csd_pkg::SUM_POS);
  localparam logic [2:0] IDX_FLAG = 3'(csd_pkg::HELD_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_KEY,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_DIRECT,
    MODE_BURST,
    MODE_FLUSH
  } mode_e;

  state_e      state_q;
  mode_e       mode_q;
  logic [PW-1:0] position_q;
  logic [9:0]  cipher_q;
  logic [7:0]  raw_q;
  logic        last_q;
  logic [7:0]  plain_q;
  logic [7:0]  key_q;
  logic [7:0]  byte8_q;
  logic [7:0]  byte9_q;
  logic [7:0]  sum_q;
  logic        enc_q;
  logic [2:0]  idx_q;
  logic [2:0]  cnt_q;
  logic [7:0]  held_q [csd_pkg::HELD_DEPTH];

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        run_end_q;
  logic        file_end_q;
  logic        header_bad_q;

  csd_pkg::lcg_ctrl_t lcg_ctrl;
  logic [7:0]  lcg_byte;

  // shared LCG unit
  csd_lcg u_lcg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lcg_ctrl),
    .key_byte_o (lcg_byte)
  );

  logic        in_fire;
  logic        slot_free;
  logic [PW-1:0] held_off;
  logic [7:0]  held_rd;
  logic [PW-1:0] wpos;
  logic [7:0]  wraw;
  logic        covered;
  logic [7:0]  plain_d;
  logic        is_flag_slot;
  logic        is_sum;
  logic        emit_final;
  logic [7:0]  emit_byte;
  logic        emit_bad;
  logic        archive_done;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign held_off = position_q - POS_FIRST;
  assign held_rd  = held_q[idx_q];

  // byte under decode: a held byte or byte 16 in a burst, else the input
  always_comb begin
    if (mode_q == MODE_BURST) begin
      wpos = POS_FIRST + PW'(idx_q);
      wraw = (idx_q == IDX_FLAG) ? raw_q : held_rd;
    end else begin
      wpos = position_q;
      wraw = raw_q;
    end
    covered = enc_q && (wpos >= POS_FIRST) && (CW'(wpos) < CW'(cipher_q));
    plain_d = (covered && (wpos != POS_FLAG)) ? (wraw ^ key_q) : wraw;
  end

  // result value and end flags
  always_comb begin
    is_flag_slot = (mode_q == MODE_BURST) && (idx_q == IDX_FLAG);
    is_sum       = (mode_q == MODE_DIRECT) && (position_q == POS_SUM);
    case (mode_q)
      MODE_DIRECT: emit_final = 1'b1;
      MODE_BURST:  emit_final = (idx_q == IDX_FLAG);
      MODE_FLUSH:  emit_final = (idx_q == cnt_q);
      default:     emit_final = 1'b1;
    endcase
    if (is_flag_slot) begin
      emit_byte = 8'h00;
    end else if (is_sum && enc_q) begin
      emit_byte = 8'h00 - (sum_q - byte8_q);
    end else begin
      emit_byte = plain_q;
    end
    emit_bad = is_sum && ((sum_q + plain_q) != 8'h00);
  end

  assign archive_done = (state_q == ST_EMIT) && slot_free && emit_final && last_q;

  // LCG control
  always_comb begin
    lcg_ctrl.restart = archive_done ||
                       (in_fire && (position_q == POS_FLAG));
    lcg_ctrl.step    = (state_q == ST_DEC) && covered;
  end

  // sequencer, archive state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= MODE_DIRECT;
      position_q   <= '0;
      cipher_q     <= csd_pkg::CIPHER_RESET;
      key_q        <= '0;
      byte8_q      <= '0;
      byte9_q      <= '0;
      sum_q        <= '0;
      enc_q        <= 1'b0;
      idx_q        <= '0;
      cnt_q        <= '0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cipher_q <= cfg_data_i;
      end
      // output valid: set when the emit step loads, cleared when taken
      if ((state_q == ST_EMIT) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            raw_q  <= data_byte_i;
            last_q <= last_byte_i;
            idx_q  <= '0;
            if (position_q < POS_FIRST) begin
              if (position_q == PW'(8)) begin
                byte8_q <= data_byte_i;
              end
              if (position_q == PW'(9)) begin
                byte9_q <= data_byte_i;
              end
              sum_q   <= sum_q + data_byte_i;
              plain_q <= data_byte_i;
              mode_q  <= MODE_DIRECT;
              state_q <= ST_EMIT;
            end else if (position_q < POS_FLAG) begin
              held_q[held_off[2:0]] <= data_byte_i;
              if (last_byte_i) begin
                cnt_q   <= held_off[2:0];
                mode_q  <= MODE_FLUSH;
                state_q <= ST_FLUSH;
              end else begin
                position_q <= position_q + 1'b1;
              end
            end else if (position_q == POS_FLAG) begin
              enc_q   <= (data_byte_i != 8'h00);
              key_q   <= data_byte_i - byte9_q + byte8_q;
              byte8_q <= data_byte_i;
              mode_q  <= MODE_BURST;
              state_q <= ST_DEC;
            end else begin
              mode_q  <= MODE_DIRECT;
              state_q <= ST_DEC;
            end
          end
        end
        ST_DEC: begin
          plain_q <= plain_d;
          if (wpos < POS_SUM) begin
            sum_q <= sum_q + plain_d;
          end
          state_q <= covered ? ST_KEY : ST_EMIT;
        end
        ST_KEY: begin
          key_q   <= key_q + plain_q + lcg_byte;
          state_q <= ST_EMIT;
        end
        ST_FLUSH: begin
          plain_q <= held_rd;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_byte_q   <= emit_byte;
            run_end_q    <= emit_final;
            file_end_q   <= emit_final && last_q;
            header_bad_q <= emit_bad;
            if (!emit_final) begin
              idx_q   <= idx_q + 1'b1;
              state_q <= (mode_q == MODE_FLUSH) ? ST_FLUSH : ST_DEC;
            end else begin
              state_q <= ST_IDLE;
              if (last_q) begin
                position_q <= '0;
                key_q      <= '0;
                byte8_q    <= '0;
                byte9_q    <= '0;
                sum_q      <= '0;
                enc_q      <= 1'b0;
              end else if (position_q != POS_MAX) begin
                position_q <= position_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_end_o    = run_end_q;
  assign file_end_o   = file_end_q;
  assign header_bad_o = header_bad_q;

`ifndef SYNTHESIS
  // key update only follows a decode step that advanced the LCG
  a_key_after_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KEY) |-> $past(state_q == ST_DEC))
    else $error("key update without preceding decode");

  // a new result is only loaded from the emit step
  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result loaded outside emit step");

  // file end only marks the closing result of a transaction
  a_file_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && file_end_q) |-> run_end_q)
    else $error("file_end without run_end");

  // position saturates at the archive limit POS_MAX
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    position_q <= POS_MAX)
    else $error("position out of range");

  // burst index never passes the byte 16 slot
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC && mode_q == MODE_BURST) |-> (idx_q <= IDX_FLAG))
    else $error("burst index out of range");
`endif

endmodule

FILE: src/csd_lcg.sv
module csd_lcg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csd_pkg::lcg_ctrl_t ctrl_i,
  output logic [7:0]        key_byte_o
);

  logic [31:0] seed_q, seed_d;

  // one LCG step per request; restart wins
  always_comb begin
    seed_d = seed_q;
    if (ctrl_i.restart) begin
      seed_d = csd_pkg::LCG_SEED;
    end else if (ctrl_i.step) begin
      seed_d = seed_q * csd_pkg::LCG_MUL + csd_pkg::LCG_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= csd_pkg::LCG_SEED;
    end else begin
      seed_q <= seed_d;
    end
  end

  // low byte of bits 31..16
  assign key_byte_o = seed_q[23:16];

endmodule
